// ===== hw/rtl/kvr_pkg.sv =====
// Package for the keycode layout remapper: word types, key and modifier constants,
// the fixed rule ROM and its lookup function.
// No dependencies; every other file of the block imports it.
package kvr_pkg;

    localparam int SLOT_COUNT_DEF = 16;

    localparam logic [15:0] PAGE_KEYBOARD = 16'h0007;
    localparam logic [7:0]  SHIFT_MASK    = 8'h22;
    localparam logic [7:0]  ALT_MASK      = 8'h44;
    localparam logic [7:0]  KEY_LANG5     = 8'h94;
    localparam logic [7:0]  KEY_GRAVE     = 8'h35;
    localparam int          RULE_COUNT    = 20;

    typedef struct packed {
        logic [15:0] hid_page;
        logic [7:0]  key_code;
        logic        pressed;
        logic [7:0]  modifiers;
    } t_kvr_in;

    typedef struct packed {
        logic [7:0] out_key_code;
        logic [7:0] out_modifiers;
    } t_kvr_out;

    // Search word that walks the row of slot cells, one cell per cycle.
    typedef struct packed {
        logic       valid;
        logic [7:0] key;
        logic       hit;
        logic       free;
        logic [7:0] hit_outk;
        logic       hit_oshift;
    } t_scan;

    // Commit command broadcast to every cell once the search has finished.
    typedef struct packed {
        logic       wr;
        logic       clr;
        logic       hit;
        logic [7:0] key;
        logic [7:0] outk;
        logic       oshift;
    } t_slot_cmd;

    typedef struct packed {
        logic [7:0] trig;
        logic       trig_shift;
        logic [7:0] outk;
        logic       out_shift;
    } t_rule;

    typedef struct packed {
        logic       match;
        logic [7:0] outk;
        logic       out_shift;
    } t_rule_hit;

    localparam t_rule RULE_ROM [RULE_COUNT] = '{
        '{8'h35, 1'b0, 8'h2F, 1'b1},
        '{8'h35, 1'b1, 8'h2E, 1'b1},
        '{8'h1F, 1'b1, 8'h2F, 1'b0},
        '{8'h23, 1'b1, 8'h2E, 1'b0},
        '{8'h24, 1'b1, 8'h23, 1'b1},
        '{8'h25, 1'b1, 8'h34, 1'b0},
        '{8'h26, 1'b1, 8'h25, 1'b1},
        '{8'h27, 1'b1, 8'h26, 1'b1},
        '{8'h2D, 1'b1, 8'h87, 1'b1},
        '{8'h2E, 1'b0, 8'h2D, 1'b1},
        '{8'h2E, 1'b1, 8'h33, 1'b1},
        '{8'h2F, 1'b0, 8'h30, 1'b0},
        '{8'h2F, 1'b1, 8'h30, 1'b1},
        '{8'h30, 1'b0, 8'h31, 1'b0},
        '{8'h30, 1'b1, 8'h31, 1'b1},
        '{8'h31, 1'b0, 8'h89, 1'b0},
        '{8'h31, 1'b1, 8'h89, 1'b1},
        '{8'h33, 1'b1, 8'h34, 1'b0},
        '{8'h34, 1'b0, 8'h24, 1'b1},
        '{8'h34, 1'b1, 8'h1F, 1'b1}
    };

    // The first rule in ROM order that matches the key and shift state wins.
    function automatic t_rule_hit rule_lookup(input logic [7:0] key, input logic shift);
        t_rule_hit res;
        res = '0;
        for (int r = RULE_COUNT - 1; r >= 0; r--) begin
            if (RULE_ROM[r].trig == key && RULE_ROM[r].trig_shift == shift) begin
                res.match     = 1'b1;
                res.outk      = RULE_ROM[r].outk;
                res.out_shift = RULE_ROM[r].out_shift;
            end
        end
        return res;
    endfunction

endpackage

// ===== hw/rtl/keycode_layout_remapper_top.sv =====
// Keycode layout remapper. Usage:
// The input channel (i_in_valid, o_in_stall, i_in_data) takes one key event word:
// usage page, keycode, press flag and modifier byte. The output channel
// (o_out_valid, i_out_stall, o_out_data) returns one word per event with the
// rewritten keycode and modifier byte.
// After a word is accepted a search word walks a row of SLOT_COUNT slot cells, one
// cell per cycle; when it comes out of the last cell the rule ROM result is
// combined with it, the slot table is updated and the result is registered.
// One event is handled at a time: a new word is accepted only after the result
// of the last one has been taken.
// o_in_stall is high from acceptance until the result has been taken.
// While i_out_stall is high the result word is held unchanged.
// Reset (synchronous, active low) marks every slot free and empties the channel.
// Depends on kvr_pkg and kvr_cell.
module keycode_layout_remapper_top
    import kvr_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_kvr_in  i_in_data,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_kvr_out o_out_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

    t_state    r_state;
    t_kvr_in   r_in;
    t_scan     r_tok_head;
    t_scan     n_tok_head;
    t_kvr_out  r_out;
    t_kvr_out  n_out;
    t_slot_cmd w_cmd;
    t_scan     w_tok [SLOT_COUNT + 1];
    t_scan     w_tail;
    t_rule_hit w_rule;
    logic      w_accept;
    logic      w_commit;

    assign w_accept = i_in_valid && (r_state == ST_IDLE);
    assign w_tail   = w_tok[SLOT_COUNT];
    assign w_commit = (r_state == ST_SCAN) && w_tail.valid;

    assign w_tok[0] = r_tok_head;

    for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_cell
        kvr_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_tok   (w_tok[g]),
            .i_cmd   (w_cmd),
            .o_tok   (w_tok[g + 1])
        );
    end

    // A fresh search word enters the row only in the cycle after acceptance.
    always_comb begin
        n_tok_head = '0;
        if (w_accept) begin
            n_tok_head.valid = 1'b1;
            n_tok_head.key   = i_in_data.key_code;
        end
    end

    assign w_rule = rule_lookup(r_in.key_code, (r_in.modifiers & SHIFT_MASK) != 8'h00);

    always_comb begin
        logic kb;
        logic grave_alt;
        kb        = (r_in.hid_page == PAGE_KEYBOARD);
        grave_alt = (r_in.key_code == KEY_GRAVE) && ((r_in.modifiers & ALT_MASK) != 8'h00);
        n_out.out_key_code  = r_in.key_code;
        n_out.out_modifiers = r_in.modifiers;
        w_cmd        = '0;
        w_cmd.hit    = w_tail.hit;
        w_cmd.key    = r_in.key_code;
        if (kb && r_in.pressed) begin
            if (grave_alt) begin
                n_out.out_key_code  = KEY_LANG5;
                n_out.out_modifiers = r_in.modifiers & ~(ALT_MASK | SHIFT_MASK);
                w_cmd.wr     = w_commit;
                w_cmd.outk   = KEY_LANG5;
                w_cmd.oshift = 1'b0;
            end else if (w_rule.match) begin
                n_out.out_key_code  = w_rule.outk;
                n_out.out_modifiers = w_rule.out_shift ? (r_in.modifiers | SHIFT_MASK)
                                                       : (r_in.modifiers & ~SHIFT_MASK);
                w_cmd.wr     = w_commit;
                w_cmd.outk   = w_rule.outk;
                w_cmd.oshift = w_rule.out_shift;
            end
        end else if (kb && w_tail.hit) begin
            n_out.out_key_code = w_tail.hit_outk;
            if (r_in.key_code == KEY_GRAVE && w_tail.hit_outk == KEY_LANG5) begin
                n_out.out_modifiers = r_in.modifiers & ~(ALT_MASK | SHIFT_MASK);
            end else if (w_tail.hit_oshift) begin
                n_out.out_modifiers = r_in.modifiers | SHIFT_MASK;
            end else begin
                n_out.out_modifiers = r_in.modifiers & ~SHIFT_MASK;
            end
            w_cmd.clr = w_commit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_tok_head <= '0;
            r_in       <= '0;
            r_out      <= '0;
        end else begin
            r_tok_head <= n_tok_head;
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_in    <= i_in_data;
                        r_state <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (w_commit) begin
                        r_out   <= n_out;
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (!i_out_stall) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = (r_state == ST_DONE);
    assign o_out_data  = r_out;

endmodule

// ===== hw/rtl/kvr_cell.sv =====
// One slot cell of the remapper: holds a single recorded rewrite and passes the
// search word on to its neighbour. Depends on kvr_pkg.
module kvr_cell
    import kvr_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_scan     i_tok,
    input  t_slot_cmd i_cmd,
    output t_scan     o_tok
);

    logic       r_used;
    logic [7:0] r_orig;
    logic [7:0] r_outk;
    logic       r_oshift;
    logic       r_sel_hit;
    logic       r_sel_free;
    t_scan      r_tok;
    t_scan      n_tok;
    logic       w_match;
    logic       w_take;

    assign w_match = r_used && (r_orig == i_tok.key);

    always_comb begin
        n_tok = i_tok;
        if (!i_tok.hit && w_match) begin
            n_tok.hit        = 1'b1;
            n_tok.hit_outk   = r_outk;
            n_tok.hit_oshift = r_oshift;
        end
        if (!r_used) begin
            n_tok.free = 1'b1;
        end
    end

    // A matching slot takes precedence over the first free one.
    assign w_take = i_cmd.wr && (i_cmd.hit ? r_sel_hit : r_sel_free);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used     <= 1'b0;
            r_sel_hit  <= 1'b0;
            r_sel_free <= 1'b0;
            r_tok      <= '0;
        end else begin
            r_tok <= n_tok;
            if (i_tok.valid) begin
                r_sel_hit  <= w_match && !i_tok.hit;
                r_sel_free <= !r_used && !i_tok.free;
            end
            if (w_take) begin
                r_used <= 1'b1;
            end else if (i_cmd.clr && r_sel_hit) begin
                r_used <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_orig   <= i_cmd.key;
            r_outk   <= i_cmd.outk;
            r_oshift <= i_cmd.oshift;
        end
    end

    assign o_tok = r_tok;

endmodule

// ===== hw/rtl/kvr_checker.sv =====
// Port-level checker for the keycode layout remapper, bound to the top level.
// Depends on kvr_pkg and keycode_layout_remapper_top.
module kvr_checker
    import kvr_pkg::*;
(
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     i_in_valid,
    input logic     i_in_stall,
    input logic     i_out_valid,
    input logic     i_out_stall,
    input t_kvr_out i_out_data
);

    // A held result word must not move.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_stall) |=> (i_out_valid && $stable(i_out_data)))
        else $error("result word changed or vanished while stalled");

    // An accepted event blocks the input and has no result in the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !i_in_stall) |=> (i_in_stall && !i_out_valid))
        else $error("input not blocked after an accepted event");

    // Only one event is in flight, so a waiting result keeps the input blocked.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_in_stall)
        else $error("input open while a result is waiting");

    // Once the result is taken the block is free again.
    a_taken_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_stall) |=> (!i_out_valid && !i_in_stall))
        else $error("block not free after its result was taken");

endmodule

bind keycode_layout_remapper_top kvr_checker u_kvr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_stall  (o_in_stall),
    .i_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .i_out_data  (o_out_data)
);
